// ===== rtl/core/anp_pkg.sv =====
// ----------------------------------------------------------------------------
// anp_pkg: ASCII number parser package
// Widths, phase and status codes, character constants and digit decode.
// ----------------------------------------------------------------------------
`default_nettype none

package anp_pkg;

	localparam int CHAR_W   = 8;
	localparam int VALUE_W  = 64;
	localparam int STATUS_W = 2;
	localparam int RADIX_W  = 6;
	localparam int BYTES_W  = 4;
	localparam int DIGIT_W  = 7;
	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 6;

	// Product of the value and a radix, plus one digit, fits here.
	localparam int PROD_W = VALUE_W + RADIX_W;

	// Configuration register indexes
	localparam logic [CFG_IDX_W-1:0] CFG_FIXED_BASE   = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_RESULT_BYTES = 2'd1;

	localparam logic [RADIX_W-1:0] FIXED_BASE_RST   = 6'd0;
	localparam logic [BYTES_W-1:0] RESULT_BYTES_RST = 4'd8;

	// Parse phases
	localparam logic [1:0] PH_START  = 2'd0;
	localparam logic [1:0] PH_ZERO   = 2'd1;
	localparam logic [1:0] PH_DIGITS = 2'd2;
	localparam logic [1:0] PH_ENDED  = 2'd3;

	// Result status codes
	localparam logic [STATUS_W-1:0] ST_OK       = 2'd0;
	localparam logic [STATUS_W-1:0] ST_NOTATION = 2'd1;
	localparam logic [STATUS_W-1:0] ST_RANGE    = 2'd2;

	localparam logic [RADIX_W-1:0] BASE_BINARY      = 6'd2;
	localparam logic [RADIX_W-1:0] BASE_DECIMAL     = 6'd10;
	localparam logic [RADIX_W-1:0] BASE_HEXADECIMAL = 6'd16;
	localparam logic [RADIX_W-1:0] RADIX_NONE = 6'd0;

	localparam logic [CHAR_W-1:0] CH_NUL   = 8'h00;
	localparam logic [CHAR_W-1:0] CH_ZERO  = 8'h30;
	localparam logic [CHAR_W-1:0] CH_NINE  = 8'h39;
	localparam logic [CHAR_W-1:0] CH_LC_A  = 8'h61;
	localparam logic [CHAR_W-1:0] CH_LC_Z  = 8'h7a;
	localparam logic [CHAR_W-1:0] CH_UC_A  = 8'h41;
	localparam logic [CHAR_W-1:0] CH_UC_Z  = 8'h5a;
	localparam logic [CHAR_W-1:0] CH_LC_B  = 8'h62;
	localparam logic [CHAR_W-1:0] CH_UC_B  = 8'h42;
	localparam logic [CHAR_W-1:0] CH_LC_D  = 8'h64;
	localparam logic [CHAR_W-1:0] CH_UC_D  = 8'h44;
	localparam logic [CHAR_W-1:0] CH_LC_X  = 8'h78;
	localparam logic [CHAR_W-1:0] CH_UC_X  = 8'h58;

	localparam logic [DIGIT_W-1:0] NOT_A_DIGIT = 7'd64;

	// Map a character to its digit value; letters count from ten.
	function automatic logic [DIGIT_W-1:0] digit_of(input logic [CHAR_W-1:0] c);
		logic [DIGIT_W-1:0] d;
		d = NOT_A_DIGIT;
		if (c >= CH_ZERO && c <= CH_NINE)
			d = DIGIT_W'(c - CH_ZERO);
		else if (c >= CH_LC_A && c <= CH_LC_Z)
			d = DIGIT_W'(c - CH_LC_A) + 7'd10;
		else if (c >= CH_UC_A && c <= CH_UC_Z)
			d = DIGIT_W'(c - CH_UC_A) + 7'd10;
		return d;
	endfunction

endpackage

`default_nettype wire

// ===== rtl/core/anp_char_if.sv =====
// ----------------------------------------------------------------------------
// anp_char_if: character stream channel
// One ASCII character per beat, with a flag on the last one of a string.
// ----------------------------------------------------------------------------
`default_nettype none

interface anp_char_if;
	logic                        valid;
	logic                        ready;
	logic [anp_pkg::CHAR_W-1:0]  char_code;
	logic                        is_final;

	modport source (output valid, output char_code, output is_final, input ready);
	modport sink   (input valid, input char_code, input is_final, output ready);
endinterface

`default_nettype wire

// ===== rtl/core/anp_result_if.sv =====
// ----------------------------------------------------------------------------
// anp_result_if: parse result channel
// One beat per string: the parsed value and its status.
// ----------------------------------------------------------------------------
`default_nettype none

interface anp_result_if;
	logic                          valid;
	logic                          ready;
	logic [anp_pkg::VALUE_W-1:0]   parsed_value;
	logic [anp_pkg::STATUS_W-1:0]  parse_status;

	modport source (output valid, output parsed_value, output parse_status, input ready);
	modport sink   (input valid, input parsed_value, input parse_status, output ready);
endinterface

`default_nettype wire

// ===== rtl/core/anp_cfg_if.sv =====
// ----------------------------------------------------------------------------
// anp_cfg_if: configuration write channel
// One register write per beat: register index and write data.
// ----------------------------------------------------------------------------
`default_nettype none

interface anp_cfg_if;
	logic                             valid;
	logic                             ready;
	logic [anp_pkg::CFG_IDX_W-1:0]    index;
	logic [anp_pkg::CFG_DATA_W-1:0]   data;

	modport source (output valid, output index, output data, input ready);
	modport sink   (input valid, input index, input data, output ready);
endinterface

`default_nettype wire

// ===== rtl/core/ascii_number_parser.sv =====
// ----------------------------------------------------------------------------
// ascii_number_parser: ASCII unsigned integer parser with radix prefix
// Parses one character per beat into a 64-bit value, one result per string.
// ----------------------------------------------------------------------------
// The block takes one character every clock cycle, save for the stall below,
// and delivers one result, value and status, for the beat flagged final. A
// character is registered on acceptance and folded into the running value as
// it leaves that register, by a single 64 x 6 multiply-add with range checks;
// the result sits in an output register behind the input register, and a new
// character is accepted each cycle while the result waits, unless a second
// final beat would need the still-occupied output register. A
// leading "0b", "0d" or "0x" selects the radix when fixed_base is zero; the
// first error in a string is held until its final character.
`default_nettype none

module ascii_number_parser (
	input  wire           clk,
	input  wire           arst_n,
	anp_char_if.sink      chars,
	anp_result_if.source  result,
	anp_cfg_if.sink       cfg
);

	// Configuration registers
	logic [anp_pkg::RADIX_W-1:0]  fixed_base_q;
	logic [anp_pkg::BYTES_W-1:0]  result_bytes_q;

	// Input stage
	logic                         valid_s1;
	logic [anp_pkg::CHAR_W-1:0]   char_s1;
	logic                         final_s1;

	// Parse state
	logic [1:0]                   phase_q;
	logic [anp_pkg::RADIX_W-1:0]  radix_q;
	logic [anp_pkg::VALUE_W-1:0]  acc_q;
	logic [anp_pkg::STATUS_W-1:0] err_q;

	// Output register
	logic                         out_valid_q;
	logic [anp_pkg::VALUE_W-1:0]  out_value_q;
	logic [anp_pkg::STATUS_W-1:0] out_status_q;

	logic                         adv_s1;
	logic                         in_take;

	logic [1:0]                   phase_d;
	logic [anp_pkg::RADIX_W-1:0]  radix_d;
	logic [anp_pkg::VALUE_W-1:0]  acc_d;
	logic [anp_pkg::STATUS_W-1:0] err_d;
	logic [anp_pkg::RADIX_W-1:0]  default_radix;
	logic [anp_pkg::RADIX_W-1:0]  radix_use;
	logic [anp_pkg::RADIX_W-1:0]  prefix_sel;
	logic                         take;
	logic [anp_pkg::DIGIT_W-1:0]  digit;
	logic [anp_pkg::PROD_W-1:0]   mac;
	logic [5:0]                   limit_shift;
	logic                         over_limit;

	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fixed_base_q   <= anp_pkg::FIXED_BASE_RST;
			result_bytes_q <= anp_pkg::RESULT_BYTES_RST;
		end else if (cfg.valid) begin
			case (cfg.index)
				anp_pkg::CFG_FIXED_BASE:   fixed_base_q <= cfg.data;
				anp_pkg::CFG_RESULT_BYTES: result_bytes_q <= cfg.data[anp_pkg::BYTES_W-1:0];
				default: ;
			endcase
		end
	end

	// A final beat may only advance once the output register is free.
	assign adv_s1      = valid_s1 && (!final_s1 || !out_valid_q || result.ready);
	assign chars.ready = !valid_s1 || adv_s1;
	assign in_take     = chars.valid && chars.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (chars.ready) begin
			valid_s1 <= chars.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_take) begin
			char_s1  <= chars.char_code;
			final_s1 <= chars.is_final;
		end
	end

	assign default_radix = (fixed_base_q != anp_pkg::RADIX_NONE) ? fixed_base_q
		: anp_pkg::BASE_DECIMAL;
	assign digit = anp_pkg::digit_of(char_s1);

	always_comb begin
		case (char_s1)
			anp_pkg::CH_LC_B, anp_pkg::CH_UC_B: prefix_sel = anp_pkg::BASE_BINARY;
			anp_pkg::CH_LC_D, anp_pkg::CH_UC_D: prefix_sel = anp_pkg::BASE_DECIMAL;
			anp_pkg::CH_LC_X, anp_pkg::CH_UC_X: prefix_sel = anp_pkg::BASE_HEXADECIMAL;
			default:                            prefix_sel = anp_pkg::RADIX_NONE;
		endcase
	end

	always_comb begin
		phase_d   = phase_q;
		radix_d   = radix_q;
		radix_use = radix_q;
		take      = 1'b0;
		if (err_q == anp_pkg::ST_OK) begin
			case (phase_q)
				anp_pkg::PH_START: begin
					radix_d   = default_radix;
					radix_use = default_radix;
					if (char_s1 == anp_pkg::CH_NUL) begin
						phase_d = anp_pkg::PH_ENDED;
					end else if (char_s1 == anp_pkg::CH_ZERO) begin
						phase_d = anp_pkg::PH_ZERO;
					end else begin
						phase_d = anp_pkg::PH_DIGITS;
						take    = 1'b1;
					end
				end
				anp_pkg::PH_ZERO: begin
					if (char_s1 == anp_pkg::CH_NUL) begin
						phase_d = anp_pkg::PH_ENDED;
					end else if (prefix_sel != anp_pkg::RADIX_NONE) begin
						radix_d = prefix_sel;
						phase_d = anp_pkg::PH_DIGITS;
					end else begin
						phase_d = anp_pkg::PH_DIGITS;
						take    = 1'b1;
					end
				end
				anp_pkg::PH_DIGITS: begin
					if (char_s1 == anp_pkg::CH_NUL)
						phase_d = anp_pkg::PH_ENDED;
					else
						take = 1'b1;
				end
				default: ;
			endcase
		end
	end

	// value * radix + digit; anything above bit 63 is an overflow.
	assign mac = (anp_pkg::PROD_W'(acc_q) * anp_pkg::PROD_W'(radix_use))
		+ anp_pkg::PROD_W'(digit);

	assign limit_shift = {result_bytes_q[2:0], 3'b000};
	assign over_limit  = !result_bytes_q[3]
		&& ((mac[anp_pkg::VALUE_W-1:0] >> limit_shift) != '0);

	always_comb begin
		acc_d = acc_q;
		err_d = err_q;
		if (err_q == anp_pkg::ST_OK && phase_q == anp_pkg::PH_ZERO
			&& char_s1 != anp_pkg::CH_NUL && prefix_sel != anp_pkg::RADIX_NONE
			&& fixed_base_q != anp_pkg::RADIX_NONE && fixed_base_q != prefix_sel) begin
			err_d = anp_pkg::ST_NOTATION;
		end
		if (take) begin
			if (anp_pkg::RADIX_W'(digit) >= radix_use || digit[anp_pkg::DIGIT_W-1]) begin
				err_d = anp_pkg::ST_NOTATION;
			end else if (mac[anp_pkg::PROD_W-1:anp_pkg::VALUE_W] != '0) begin
				err_d = anp_pkg::ST_RANGE;
			end else begin
				acc_d = mac[anp_pkg::VALUE_W-1:0];
				if (over_limit)
					err_d = anp_pkg::ST_RANGE;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= anp_pkg::PH_START;
			radix_q <= anp_pkg::BASE_DECIMAL;
			acc_q   <= '0;
			err_q   <= anp_pkg::ST_OK;
		end else if (adv_s1) begin
			if (final_s1) begin
				// Clear for the next string
				phase_q <= anp_pkg::PH_START;
				radix_q <= default_radix;
				acc_q   <= '0;
				err_q   <= anp_pkg::ST_OK;
			end else begin
				phase_q <= phase_d;
				radix_q <= radix_d;
				acc_q   <= acc_d;
				err_q   <= err_d;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (adv_s1 && final_s1) begin
			out_valid_q <= 1'b1;
		end else if (result.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (adv_s1 && final_s1) begin
			out_value_q  <= (err_d == anp_pkg::ST_OK) ? acc_d : '0;
			out_status_q <= err_d;
		end
	end

	assign result.valid        = out_valid_q;
	assign result.parsed_value = out_value_q;
	assign result.parse_status = out_status_q;

endmodule

`default_nettype wire

// ===== test/ascii_number_parser_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ascii_number_parser_tb: self-checking bench for the ASCII number parser
// Streams character strings with random idle and stall on both sides,
// predicts the value and status of every string, and checks each result beat
// in order against that prediction.
// ----------------------------------------------------------------------------
module ascii_number_parser_tb;
	import anp_pkg::*;

	localparam logic [CFG_IDX_W-1:0] CFG_SPARE_LO = 2'd2;
	localparam logic [CFG_IDX_W-1:0] CFG_SPARE_HI = 2'd3;
	localparam int IDLE_MAX = 19;

	typedef struct packed {
		logic [VALUE_W-1:0]  value;
		logic [STATUS_W-1:0] status;
	} number_t;

	logic clk;
	logic arst_n;

	anp_char_if   chars_ch();
	anp_result_if result_ch();
	anp_cfg_if    cfg_ch();

	ascii_number_parser u_top (
		.clk    (clk),
		.arst_n (arst_n),
		.chars  (chars_ch),
		.result (result_ch),
		.cfg    (cfg_ch)
	);

	// Register copies and per-string parse state
	logic [RADIX_W-1:0]  base_reg   = FIXED_BASE_RST;
	logic [BYTES_W-1:0]  bytes_reg  = RESULT_BYTES_RST;
	logic [1:0]          phase_now  = PH_START;
	logic [RADIX_W-1:0]  radix_now  = BASE_DECIMAL;
	logic [VALUE_W-1:0]  value_now  = '0;
	logic [STATUS_W-1:0] status_now = ST_OK;
	number_t             number_q[$];

	int mismatch_count = 0;
	int chars_sent     = 0;
	int tx_idle_max    = IDLE_MAX;
	int rx_idle_max    = IDLE_MAX;
	int hold_request   = 0;

	function automatic logic [RADIX_W-1:0] start_radix();
		return (base_reg != RADIX_NONE) ? base_reg : BASE_DECIMAL;
	endfunction

	function automatic logic [DIGIT_W-1:0] digit_value(input logic [CHAR_W-1:0] c);
		if (c >= CH_ZERO && c <= CH_NINE)
			return DIGIT_W'(c - CH_ZERO);
		if (c >= CH_LC_A && c <= CH_LC_Z)
			return DIGIT_W'(c - CH_LC_A) + DIGIT_W'(10);
		if (c >= CH_UC_A && c <= CH_UC_Z)
			return DIGIT_W'(c - CH_UC_A) + DIGIT_W'(10);
		return NOT_A_DIGIT;
	endfunction

	function automatic logic [VALUE_W-1:0] value_ceiling();
		if (bytes_reg >= BYTES_W'(8))
			return '1;
		return (VALUE_W'(1) << (bytes_reg * 8)) - VALUE_W'(1);
	endfunction

	function automatic void fold_digit(input logic [CHAR_W-1:0] c);
		logic [DIGIT_W-1:0] d;
		logic [PROD_W-1:0]  wide;
		d = digit_value(c);
		if (d >= DIGIT_W'(radix_now)) begin
			status_now = ST_NOTATION;
			return;
		end
		// widen so a carry past 64 bits shows up in the top bits
		wide = PROD_W'(value_now) * PROD_W'(radix_now) + PROD_W'(d);
		if (wide[PROD_W-1:VALUE_W] != '0) begin
			status_now = ST_RANGE;
			return;
		end
		value_now = wide[VALUE_W-1:0];
		if (value_now > value_ceiling())
			status_now = ST_RANGE;
	endfunction

	function automatic void fold_char(input logic [CHAR_W-1:0] c, input logic fin);
		logic [RADIX_W-1:0] sel;
		number_t done;
		if (status_now == ST_OK) begin
			case (phase_now)
			PH_START: begin
				radix_now = start_radix();
				if (c == CH_NUL)
					phase_now = PH_ENDED;
				else if (c == CH_ZERO)
					phase_now = PH_ZERO;
				else begin
					phase_now = PH_DIGITS;
					fold_digit(c);
				end
			end
			PH_ZERO: begin
				sel = RADIX_NONE;
				if (c == CH_LC_B || c == CH_UC_B)
					sel = BASE_BINARY;
				else if (c == CH_LC_D || c == CH_UC_D)
					sel = BASE_DECIMAL;
				else if (c == CH_LC_X || c == CH_UC_X)
					sel = BASE_HEXADECIMAL;
				if (c == CH_NUL)
					phase_now = PH_ENDED;
				else if (sel != RADIX_NONE) begin
					radix_now = sel;
					phase_now = PH_DIGITS;
					if (base_reg != RADIX_NONE && base_reg != sel)
						status_now = ST_NOTATION;
				end else begin
					phase_now = PH_DIGITS;
					fold_digit(c);
				end
			end
			PH_DIGITS: begin
				if (c == CH_NUL)
					phase_now = PH_ENDED;
				else
					fold_digit(c);
			end
			default: ;
			endcase
		end
		if (fin) begin
			done.value  = (status_now == ST_OK) ? value_now : '0;
			done.status = status_now;
			number_q.push_back(done);
			phase_now  = PH_START;
			radix_now  = start_radix();
			value_now  = '0;
			status_now = ST_OK;
		end
	endfunction

	initial begin
		clk = 1'b0;
		forever #6 clk = ~clk;
	end

	initial begin
		#5_000_000;
		$display("Verification failed");
		$finish;
	end

	// Track every accepted beat on the register and character channels
	always @(posedge clk) begin
		if (arst_n && cfg_ch.valid && cfg_ch.ready) begin
			if (cfg_ch.index == CFG_FIXED_BASE)
				base_reg = cfg_ch.data;
			else if (cfg_ch.index == CFG_RESULT_BYTES)
				bytes_reg = cfg_ch.data[BYTES_W-1:0];
		end
		if (arst_n && chars_ch.valid && chars_ch.ready)
			fold_char(chars_ch.char_code, chars_ch.is_final);
	end

	always @(posedge clk) begin
		number_t want;
		if (result_ch.valid && result_ch.ready) begin
			if (number_q.size() == 0) begin
				$error("unexpected result beat: value %h status %0d",
					result_ch.parsed_value, result_ch.parse_status);
				mismatch_count++;
			end else begin
				want = number_q.pop_front();
				if (result_ch.parsed_value !== want.value) begin
					$error("parsed_value: expected %h, got %h",
						want.value, result_ch.parsed_value);
					mismatch_count++;
				end
				if (result_ch.parse_status !== want.status) begin
					$error("parse_status: expected %0d, got %0d",
						want.status, result_ch.parse_status);
					mismatch_count++;
				end
			end
		end
	end

	// Result receiver: random stall per beat, plus a long hold-off on request
	initial begin
		int stall;
		result_ch.ready <= 1'b0;
		@(posedge clk);
		forever begin
			if (hold_request > 0) begin
				result_ch.ready <= 1'b0;
				repeat (hold_request) @(posedge clk);
				hold_request = 0;
			end
			stall = $urandom_range(rx_idle_max, 0);
			if (stall > 0) begin
				result_ch.ready <= 1'b0;
				repeat (stall) @(posedge clk);
			end
			result_ch.ready <= 1'b1;
			do @(posedge clk); while (!result_ch.valid && hold_request == 0);
		end
	end

	task automatic send_char(input logic [CHAR_W-1:0] c, input logic fin);
		int gap;
		gap = $urandom_range(tx_idle_max, 0);
		if (gap > 0) begin
			chars_ch.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		chars_ch.valid     <= 1'b1;
		chars_ch.char_code <= c;
		chars_ch.is_final  <= fin;
		do @(posedge clk); while (!chars_ch.ready);
		chars_sent++;
	endtask

	task automatic send_text(input string s);
		for (int i = 0; i < s.len(); i++)
			send_char(s[i], i == s.len() - 1);
	endtask

	// Drop the character stream and wait until the block has gone quiet
	task automatic settle();
		chars_ch.valid <= 1'b0;
		@(posedge clk);
		while (number_q.size() != 0) @(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic cfg_beat(input logic [CFG_IDX_W-1:0] idx,
			input logic [CFG_DATA_W-1:0] data);
		cfg_ch.valid <= 1'b1;
		cfg_ch.index <= idx;
		cfg_ch.data  <= data;
		do @(posedge clk); while (!cfg_ch.ready);
	endtask

	task automatic program_regs(input logic [CFG_DATA_W-1:0] base_data,
			input logic [CFG_DATA_W-1:0] bytes_data, input bit poke_spare);
		settle();
		cfg_beat(CFG_FIXED_BASE, base_data);
		if (poke_spare) begin
			cfg_beat(CFG_SPARE_LO, CFG_DATA_W'($urandom_range(63, 0)));
			cfg_beat(CFG_SPARE_HI, CFG_DATA_W'($urandom_range(63, 0)));
		end
		cfg_beat(CFG_RESULT_BYTES, bytes_data);
		cfg_ch.valid <= 1'b0;
	endtask

	function automatic logic [CHAR_W-1:0] digit_char(input int v);
		if (v < 10)
			return CH_ZERO + CHAR_W'(v);
		return ($urandom_range(1, 0) ? CH_LC_A : CH_UC_A) + CHAR_W'(v - 10);
	endfunction

	// Mostly well-formed numbers, some with one corrupted character, rest noise
	task automatic send_random_string();
		logic [CHAR_W-1:0] text[$];
		int form, len, radix, top, spot;
		form  = $urandom_range(99, 0);
		radix = int'(start_radix());
		if (form < 85) begin
			if ($urandom_range(99, 0) < ((base_reg == RADIX_NONE) ? 60 : 20)) begin
				text.push_back(CH_ZERO);
				case ($urandom_range(2, 0))
				0: begin
					text.push_back($urandom_range(1, 0) ? CH_LC_B : CH_UC_B);
					if (base_reg == RADIX_NONE)
						radix = int'(BASE_BINARY);
				end
				1: begin
					text.push_back($urandom_range(1, 0) ? CH_LC_D : CH_UC_D);
					if (base_reg == RADIX_NONE)
						radix = int'(BASE_DECIMAL);
				end
				default: begin
					text.push_back($urandom_range(1, 0) ? CH_LC_X : CH_UC_X);
					if (base_reg == RADIX_NONE)
						radix = int'(BASE_HEXADECIMAL);
				end
				endcase
			end
			if ($urandom_range(9, 0) == 0)
				len = $urandom_range(24, 9);
			else
				len = $urandom_range(8, (text.size() == 0) ? 1 : 0);
			top = (radix > 36) ? 35 : radix - 1;
			for (int i = 0; i < len; i++)
				text.push_back(digit_char($urandom_range(top, 0)));
			if (form >= 70) begin
				spot = $urandom_range(text.size() - 1, 0);
				text[spot] = CHAR_W'($urandom_range(255, 0));
			end
		end else begin
			len = $urandom_range(6, 1);
			for (int i = 0; i < len; i++)
				text.push_back(CHAR_W'($urandom_range(255, 0)));
		end
		foreach (text[i])
			send_char(text[i], i == text.size() - 1);
	endtask

	task automatic test_prefixes();
		send_text("0");
		send_text("0x");
		send_text("0b11");
		send_text("0Xf");
	endtask

	task automatic test_bad_notation();
		send_text("7:");
		// first error holds even though the next character is a digit
		send_text("a0");
		// NUL ends the string; the trailing byte is ignored
		send_char("5", 1'b0);
		send_char(CH_NUL, 1'b0);
		send_char(8'hFF, 1'b1);
		send_char(CH_ZERO, 1'b0);
		send_char(CH_NUL, 1'b1);
	endtask

	task automatic test_limits_and_bases();
		program_regs(BASE_HEXADECIMAL, CFG_DATA_W'(1), 1'b1);
		send_text("0d1");
		send_text("100");
		// base above 36 takes every letter; a zero-byte limit rejects anything but 0
		program_regs(CFG_DATA_W'(40), CFG_DATA_W'(0), 1'b0);
		send_text("z");
		send_text("0");
	endtask

	task automatic test_random_strings();
		int start;
		logic [CFG_DATA_W-1:0] base_pick;
		for (int p = 0; p < 8; p++) begin
			case (p)
			0: program_regs(FIXED_BASE_RST, CFG_DATA_W'(RESULT_BYTES_RST), 1'b0);
			1: program_regs('1, '1, 1'b1);
			default: begin
				case ($urandom_range(4, 0))
				0, 1: base_pick = RADIX_NONE;
				2: base_pick = ($urandom_range(1, 0)) ? BASE_BINARY : BASE_HEXADECIMAL;
				3: base_pick = CFG_DATA_W'($urandom_range(36, 1));
				default: base_pick = CFG_DATA_W'($urandom_range(63, 37));
				endcase
				program_regs(base_pick, CFG_DATA_W'($urandom_range(63, 0)),
					bit'($urandom_range(1, 0)));
			end
			endcase
			start = chars_sent;
			while (chars_sent - start < 95) begin
				tx_idle_max = ($urandom_range(3, 0) == 0) ? 0 : IDLE_MAX;
				rx_idle_max = ($urandom_range(3, 0) == 0) ? 0 : IDLE_MAX;
				send_random_string();
			end
		end
	endtask

	// Hold the result side off while characters stream in back to back
	task automatic test_output_backpressure();
		program_regs(RADIX_NONE, CFG_DATA_W'(RESULT_BYTES_RST), 1'b0);
		tx_idle_max  = 0;
		rx_idle_max  = 0;
		hold_request = 150;
		for (int i = 0; i < 40; i++) begin
			if ($urandom_range(1, 0))
				send_char(digit_char($urandom_range(9, 0)), 1'b0);
			send_char(digit_char($urandom_range(9, 0)), 1'b1);
		end
		tx_idle_max = IDLE_MAX;
		rx_idle_max = IDLE_MAX;
	endtask

	initial begin
		arst_n             <= 1'b0;
		chars_ch.valid     <= 1'b0;
		chars_ch.char_code <= '0;
		chars_ch.is_final  <= 1'b0;
		cfg_ch.valid       <= 1'b0;
		cfg_ch.index       <= CFG_FIXED_BASE;
		cfg_ch.data        <= '0;
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;

		test_prefixes();
		test_bad_notation();
		test_limits_and_bases();
		test_random_strings();
		test_output_backpressure();

		settle();
		if (mismatch_count == 0)
			$display("Verification passed");
		else
			$display("Verification failed");
		$finish;
	end

endmodule

// ===== sim.f =====
rtl/core/anp_pkg.sv
rtl/core/anp_char_if.sv
rtl/core/anp_result_if.sv
rtl/core/anp_cfg_if.sv
rtl/core/ascii_number_parser.sv
test/ascii_number_parser_tb.sv
